@@ rtl/core/hlm_pkg.sv @@
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared types and constants of the hierarchical tree lock manager.
// ----------------------------------------------------------------------------
package hlm_pkg;

  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 10;
  localparam int UID_W   = 16;
  localparam int BELOW_W = 10;
  localparam int CFG_W   = 11;

  localparam logic [BELOW_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [FUNC_W-1:0]  FUNC_RSVD = 2'd3;

  localparam logic CFG_BRANCHING  = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic [4:0]  BRANCH_RST = 5'd2;
  localparam logic [10:0] COUNT_RST  = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    OP_LOCK    = 2'd0,
    OP_UNLOCK  = 2'd1,
    OP_UPGRADE = 2'd2
  } op_t;

  typedef struct packed {
    logic              bad;
    op_t               op;
    logic [NODE_W-1:0] node;
    logic [UID_W-1:0]  uid;
  } hlm_req_t;

  typedef struct packed {
    logic               flag;
    logic [UID_W-1:0]   owner;
    logic [BELOW_W-1:0] below;
  } hlm_ent_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_EV,
    ST_W_DIV,
    ST_W_WAIT,
    ST_W_RD,
    ST_W_EV,
    ST_SC_M1,
    ST_SC_M2,
    ST_SC_M3,
    ST_SC_LVL,
    ST_SC_RD,
    ST_SC_EV,
    ST_SC_NEXT,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_LOCK_CHK,
    PH_LOCK_INC,
    PH_UNL_DEC,
    PH_UPG_SCAN,
    PH_UPG_CHK,
    PH_UPG_REL,
    PH_UPG_INC
  } phase_t;

endpackage

@@ rtl/core/tree_hierarchical_lock_manager_unit.sv @@
// ----------------------------------------------------------------------------
// tree_hierarchical_lock_manager_unit
// Lock / unlock / upgrade manager over a breadth-first numbered m-ary tree.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   in       | in_valid / in_ready   | in_func, in_node, in_user_id
//   out      | out_valid / out_ready | out_ok
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time in the engine; a 2-deep queue buffers requests.
// Each ancestor step runs the serial divider, then reads the parent entry.
// Upgrade scans the subtree twice, level by level,
// and adds one ancestor walk per released lock.
// After reset the node table is cleared, with in_ready low.
// out_ready low holds one result; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module tree_hierarchical_lock_manager_unit #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_BRANCH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hlm_pkg::FUNC_W-1:0]    in_func,
  input  logic [hlm_pkg::NODE_W-1:0]    in_node,
  input  logic [hlm_pkg::UID_W-1:0]     in_user_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [hlm_pkg::CFG_W-1:0]     cfg_data
);
  import hlm_pkg::*;

  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int BW = $clog2(MAX_BRANCH + 1);

  logic [4:0]  branch_r;
  logic [10:0] count_r;
  logic [BW-1:0] m_eff;
  logic [NW-1:0] cnt_eff;
  logic        req_valid, req_pop, clear_done;
  hlm_req_t    req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_r <= BRANCH_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BRANCHING) begin
        branch_r <= cfg_data[4:0];
      end else begin
        count_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (branch_r == '0) begin
      m_eff = BW'(1);
    end else if (32'(branch_r) > MAX_BRANCH) begin
      m_eff = BW'(MAX_BRANCH);
    end else begin
      m_eff = BW'(branch_r);
    end
    if (32'(count_r) > MAX_NODES) begin
      cnt_eff = NW'(MAX_NODES);
    end else begin
      cnt_eff = NW'(count_r);
    end
  end

  hlm_front #(.NW(NW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (clear_done),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_node    (in_node),
    .in_user_id (in_user_id),
    .cnt_eff    (cnt_eff),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop)
  );

  hlm_back #(.MAX_NODES(MAX_NODES), .NW(NW), .BW(BW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop),
    .m_eff      (m_eff),
    .cnt_eff    (cnt_eff),
    .clear_done (clear_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ok     (out_ok)
  );

endmodule

@@ rtl/core/hlm_front.sv @@
// ----------------------------------------------------------------------------
// hlm_front
// Accepts request items, flags refused ones and queues them for the engine.
// ----------------------------------------------------------------------------
module hlm_front #(
  parameter int NW = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    enable,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [hlm_pkg::FUNC_W-1:0] in_func,
  input  logic [hlm_pkg::NODE_W-1:0] in_node,
  input  logic [hlm_pkg::UID_W-1:0]  in_user_id,
  input  logic [NW-1:0]           cnt_eff,
  output logic                    req_valid,
  output hlm_pkg::hlm_req_t       req,
  input  logic                    req_pop
);
  import hlm_pkg::*;

  hlm_req_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  hlm_req_t   ent;
  logic       push;

  always_comb begin
    ent.bad  = (32'(in_node) >= 32'(cnt_eff)) || (in_func == FUNC_RSVD);
    ent.op   = ent.bad ? OP_LOCK : op_t'(in_func);
    ent.node = in_node;
    ent.uid  = in_user_id;
  end

  assign in_ready  = enable && (fill_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign req_valid = (fill_r != 2'd0);
  assign req       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (req_pop) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(req_pop);
    end
  end

endmodule

@@ rtl/core/hlm_div.sv @@
// ----------------------------------------------------------------------------
// hlm_div
// Bit-serial divider giving the parent index (x - 1) / m.
// ----------------------------------------------------------------------------
module hlm_div #(
  parameter int NW = 11,
  parameter int BW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] x,
  input  logic [BW-1:0] m,
  output logic          done,
  output logic [NW-1:0] q
);
  localparam int CW = $clog2(NW + 1);

  logic [BW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [BW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign ge     = (rem_sh >= {1'b0, m});
  assign done   = done_r;
  assign q      = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= x - NW'(1);
      cnt_r <= CW'(NW);
    end else if (busy_r) begin
      rem_r <= ge ? BW'(rem_sh - {1'b0, m}) : BW'(rem_sh);
      quo_r <= {quo_r[NW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/hlm_back.sv @@
// ----------------------------------------------------------------------------
// hlm_back
// Lock engine: node table, ancestor walks, subtree scans and result register.
// ----------------------------------------------------------------------------
module hlm_back #(
  parameter int MAX_NODES = 1024,
  parameter int NW        = 11,
  parameter int BW        = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  hlm_pkg::hlm_req_t req,
  output logic              req_pop,
  input  logic [BW-1:0]     m_eff,
  input  logic [NW-1:0]     cnt_eff,
  output logic              clear_done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok
);
  import hlm_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW = NW + BW + 1;

  hlm_ent_t mem [MAX_NODES];
  hlm_ent_t rd_q, wd_c;
  logic     we_c;
  logic [AW-1:0] wa_c, addr_c;

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  op_t    op_r, op_nxt;
  logic [NW-1:0] node_r, node_nxt, cur_r, cur_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NW-1:0] top_r, top_nxt, j_r, j_nxt, clr_r, clr_nxt;
  logic [UID_W-1:0] uid_r, uid_nxt;
  logic [PW-1:0] mulp_r, mulp_nxt;
  logic ok_r, ok_nxt, outv_r, outv_nxt, outok_r, outok_nxt;
  logic div_start, div_done;
  logic [NW-1:0] div_q;
  logic wchk, winc;

  function automatic logic [NW-1:0] sat(input logic [PW-1:0] x, input logic [NW-1:0] c);
    sat = (x >= PW'(c)) ? c : NW'(x);
  endfunction

  hlm_div #(.NW(NW), .BW(BW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (cur_r),
    .m     (m_eff),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rd_q <= mem[addr_c];
  end

  assign wchk       = (ph_r == PH_LOCK_CHK) || (ph_r == PH_UPG_CHK);
  assign winc       = (ph_r == PH_LOCK_INC) || (ph_r == PH_UPG_INC);
  assign clear_done = (st_r != ST_CLEAR);
  assign out_valid  = outv_r;
  assign out_ok     = outok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      outv_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    op_r    <= op_nxt;
    node_r  <= node_nxt;
    uid_r   <= uid_nxt;
    cur_r   <= cur_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    top_r   <= top_nxt;
    j_r     <= j_nxt;
    mulp_r  <= mulp_nxt;
    ok_r    <= ok_nxt;
    outok_r <= outok_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    op_nxt    = op_r;
    node_nxt  = node_r;
    uid_nxt   = uid_r;
    cur_nxt   = cur_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    top_nxt   = top_r;
    j_nxt     = j_r;
    clr_nxt   = clr_r;
    mulp_nxt  = mulp_r;
    ok_nxt    = ok_r;
    outok_nxt = outok_r;
    outv_nxt  = outv_r && !out_ready;
    req_pop   = 1'b0;
    div_start = 1'b0;
    we_c      = 1'b0;
    wa_c      = cur_r[AW-1:0];
    wd_c      = rd_q;
    addr_c    = node_r[AW-1:0];

    unique case (st_r)
      ST_CLEAR: begin
        we_c = 1'b1;
        wa_c = clr_r[AW-1:0];
        wd_c = '0;
        if (32'(clr_r) == MAX_NODES - 1) begin
          st_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          req_pop  = 1'b1;
          node_nxt = NW'(req.node);
          uid_nxt  = req.uid;
          op_nxt   = req.op;
          if (req.bad) begin
            ok_nxt = 1'b0;
            st_nxt = ST_DONE;
          end else begin
            st_nxt = ST_NODE_RD;
          end
        end
      end
      ST_NODE_RD: begin
        addr_c = node_r[AW-1:0];
        st_nxt = ST_NODE_EV;
      end
      ST_NODE_EV: begin
        ok_nxt  = 1'b0;
        st_nxt  = ST_DONE;
        cur_nxt = node_r;
        lo_nxt  = node_r;
        hi_nxt  = node_r;
        unique case (op_r)
          OP_LOCK: begin
            if (!rd_q.flag && (rd_q.below == '0)) begin
              ph_nxt = PH_LOCK_CHK;
              st_nxt = ST_W_DIV;
            end
          end
          OP_UNLOCK: begin
            if (rd_q.flag && (rd_q.owner == uid_r)) begin
              ph_nxt = PH_UNL_DEC;
              st_nxt = ST_W_DIV;
            end
          end
          OP_UPGRADE: begin
            if (!rd_q.flag && (rd_q.below != '0)) begin
              ph_nxt = PH_UPG_SCAN;
              st_nxt = ST_SC_M1;
            end
          end
          default: ;
        endcase
      end
      ST_W_DIV: begin
        if (cur_r == '0) begin
          unique case (ph_r)
            PH_LOCK_CHK: begin
              ph_nxt  = PH_LOCK_INC;
              cur_nxt = node_r;
            end
            PH_UPG_CHK: begin
              ph_nxt = PH_UPG_REL;
              lo_nxt = node_r;
              hi_nxt = node_r;
              st_nxt = ST_SC_M1;
            end
            PH_UPG_REL: st_nxt = ST_SC_NEXT;
            PH_LOCK_INC, PH_UPG_INC, PH_UNL_DEC: st_nxt = ST_FIN_RD;
            PH_UPG_SCAN: begin
              ok_nxt = 1'b0;
              st_nxt = ST_DONE;
            end
            default: ;
          endcase
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_W_WAIT;
        end
      end
      ST_W_WAIT: begin
        if (div_done) begin
          cur_nxt = div_q;
          st_nxt  = ST_W_RD;
        end
      end
      ST_W_RD: begin
        addr_c = cur_r[AW-1:0];
        st_nxt = ST_W_EV;
      end
      ST_W_EV: begin
        st_nxt = ST_W_DIV;
        if (wchk) begin
          if (rd_q.flag) begin
            ok_nxt = 1'b0;
            st_nxt = ST_DONE;
          end
        end else begin
          we_c = 1'b1;
          wa_c = cur_r[AW-1:0];
          if (winc) begin
            if (rd_q.below < COUNT_MAX) begin
              wd_c.below = rd_q.below + BELOW_W'(1);
            end
          end else if (rd_q.below != '0) begin
            wd_c.below = rd_q.below - BELOW_W'(1);
          end
        end
      end
      ST_SC_M1: begin
        mulp_nxt = PW'(lo_r) * PW'(m_eff);
        st_nxt   = ST_SC_M2;
      end
      ST_SC_M2: begin
        lo_nxt   = sat(mulp_r + PW'(1), cnt_eff);
        mulp_nxt = PW'(hi_r) * PW'(m_eff);
        st_nxt   = ST_SC_M3;
      end
      ST_SC_M3: begin
        hi_nxt = sat(mulp_r + PW'(m_eff), cnt_eff);
        st_nxt = ST_SC_LVL;
      end
      ST_SC_LVL: begin
        if (lo_r >= cnt_eff) begin
          cur_nxt = node_r;
          st_nxt  = ST_W_DIV;
          ph_nxt  = (ph_r == PH_UPG_SCAN) ? PH_UPG_CHK : PH_UPG_INC;
        end else begin
          j_nxt   = lo_r;
          top_nxt = (hi_r < cnt_eff) ? hi_r : cnt_eff - NW'(1);
          st_nxt  = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        addr_c = j_r[AW-1:0];
        st_nxt = ST_SC_EV;
      end
      ST_SC_EV: begin
        st_nxt = ST_SC_NEXT;
        if (rd_q.flag) begin
          if (ph_r == PH_UPG_SCAN) begin
            if (rd_q.owner != uid_r) begin
              ok_nxt = 1'b0;
              st_nxt = ST_DONE;
            end
          end else begin
            we_c       = 1'b1;
            wa_c       = j_r[AW-1:0];
            wd_c.flag  = 1'b0;
            wd_c.owner = '0;
            cur_nxt    = j_r;
            st_nxt     = ST_W_DIV;
          end
        end
      end
      ST_SC_NEXT: begin
        if (j_r == top_r) begin
          st_nxt = ST_SC_M1;
        end else begin
          j_nxt  = j_r + NW'(1);
          st_nxt = ST_SC_RD;
        end
      end
      ST_FIN_RD: begin
        addr_c = node_r[AW-1:0];
        st_nxt = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        we_c = 1'b1;
        wa_c = node_r[AW-1:0];
        if (op_r == OP_UNLOCK) begin
          wd_c.flag  = 1'b0;
          wd_c.owner = '0;
        end else begin
          wd_c.flag  = 1'b1;
          wd_c.owner = uid_r;
        end
        ok_nxt = 1'b1;
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!outv_r || out_ready) begin
          outv_nxt  = 1'b1;
          outok_nxt = ok_r;
          st_nxt    = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/hlm_chk.sv @@
// ----------------------------------------------------------------------------
// hlm_chk
// Port-level checks of the lock manager, bound to the top level.
// ----------------------------------------------------------------------------
module hlm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  logic [2:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok))
    else $error("result dropped or changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 3'd0)
    else $error("result without an accepted item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many items in flight");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken before table clear");

endmodule

bind tree_hierarchical_lock_manager_unit hlm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_ok    (out_ok),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
